>>> design/mpid_pkg.sv
// Package for the multichannel incremental PID controller.
// Holds the shared widths, register codes and record types; depends on nothing.
package mpid_pkg;

  localparam int unsigned NUM_CHANNELS_DEF   = 12;
  localparam int unsigned ADC_MIDSCALE_DEF   = 2048;
  localparam int unsigned INITIAL_OUTPUT_DEF = 1000;

  localparam int CH_FIELD_W = 4;
  localparam int SAMPLE_W   = 12;
  localparam int ERR_W      = 13;
  localparam int VAL_W      = 16;
  localparam int ACC_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int QUEUE_AW   = 1;

  localparam logic signed [ERR_W-1:0] ERR_MAX = 13'sd4095;
  localparam logic signed [ERR_W-1:0] ERR_MIN = -13'sd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P    = 3'd0,
    CFG_GAIN_I    = 3'd1,
    CFG_GAIN_D    = 3'd2,
    CFG_OUT_FLOOR = 3'd3,
    CFG_OUT_CEIL  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [VAL_W-1:0] gain_p;
    logic [VAL_W-1:0] gain_i;
    logic [VAL_W-1:0] gain_d;
    logic [VAL_W-1:0] out_floor;
    logic [VAL_W-1:0] out_ceil;
  } cfg_t;

  typedef struct packed {
    logic [CH_FIELD_W-1:0]   channel;
    logic signed [ERR_W-1:0] err;
  } q_item_t;

  typedef struct packed {
    logic [ACC_W-1:0]        acc;
    logic signed [ERR_W-1:0] err_prev;
    logic signed [ERR_W-1:0] err_prev2;
  } chan_state_t;

endpackage

>>> design/mpid_ifs.sv
// Handshake interfaces for the request, result and configuration channels.
// Depends on mpid_pkg for the field widths.
interface mpid_in_if;
  import mpid_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [CH_FIELD_W-1:0]      channel;
  logic signed [SAMPLE_W-1:0] target_current;
  logic [SAMPLE_W-1:0]        adc_sample;
  modport source (output valid, channel, target_current, adc_sample, input ready);
  modport sink (input valid, channel, target_current, adc_sample, output ready);
endinterface

interface mpid_out_if;
  import mpid_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CH_FIELD_W-1:0] channel_out;
  logic [VAL_W-1:0]      compare_value;
  modport source (output valid, channel_out, compare_value, input ready);
  modport sink (input valid, channel_out, compare_value, output ready);
endinterface

interface mpid_cfg_if;
  import mpid_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [VAL_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/multichannel_incremental_pid.sv
// Top level of the multichannel incremental PID controller.
// Depends on mpid_pkg, mpid_ifs, mpid_front, mpid_queue and mpid_back.
//
// Requests arrive on in_i: a channel number, a signed setpoint and a raw
// ADC sample. Each request for an existing channel produces one result on
// out_o with the channel and the new PWM compare value; a request for a
// channel number at or above NUM_CHANNELS is taken and discarded.
// Gains and output limits are written through cfg_i, which is always ready;
// they should only change while no request is in flight.
// A request moves from the queue through the read and multiply stage (s1) and
// the accumulate stage (s2) into the result register, each holding while the one
// downstream is occupied; the back end pops a request only once s1 is empty.
// A two-entry queue lets requests be taken while a result waits, and a
// stalled receiver backs the queue up until in_i.ready drops.
// Reset restores the register defaults and returns every channel to the
// initial output with cleared error history; no clearing pass is needed.
module multichannel_incremental_pid #(
  parameter int unsigned NUM_CHANNELS   = mpid_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned ADC_MIDSCALE   = mpid_pkg::ADC_MIDSCALE_DEF,
  parameter int unsigned INITIAL_OUTPUT = mpid_pkg::INITIAL_OUTPUT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mpid_in_if.sink     in_i,
  mpid_cfg_if.sink    cfg_i,
  mpid_out_if.source  out_o
);
  import mpid_pkg::*;

  cfg_t    cfg_q;
  logic    can_push, push, pop, nonempty;
  q_item_t push_item, pop_item;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p    <= 16'd480;
      cfg_q.gain_i    <= 16'd480;
      cfg_q.gain_d    <= 16'd0;
      cfg_q.out_floor <= 16'd0;
      cfg_q.out_ceil  <= 16'd2000;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_GAIN_P:    cfg_q.gain_p    <= cfg_i.data;
        CFG_GAIN_I:    cfg_q.gain_i    <= cfg_i.data;
        CFG_GAIN_D:    cfg_q.gain_d    <= cfg_i.data;
        CFG_OUT_FLOOR: cfg_q.out_floor <= cfg_i.data;
        CFG_OUT_CEIL:  cfg_q.out_ceil  <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  mpid_front #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .ADC_MIDSCALE (ADC_MIDSCALE)
  ) u_front (
    .in_i       (in_i),
    .can_push_i (can_push),
    .push_o     (push),
    .item_o     (push_item)
  );

  mpid_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .can_push_o  (can_push),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .nonempty_o  (nonempty)
  );

  mpid_back #(
    .NUM_CHANNELS   (NUM_CHANNELS),
    .INITIAL_OUTPUT (INITIAL_OUTPUT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .nonempty_i (nonempty),
    .item_i     (pop_item),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule

>>> design/mpid_front.sv
// Front end: accepts requests, drops those for absent channels and forms
// the saturated control error. Depends on mpid_pkg and mpid_in_if.
module mpid_front #(
  parameter int unsigned NUM_CHANNELS = mpid_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned ADC_MIDSCALE = mpid_pkg::ADC_MIDSCALE_DEF
) (
  mpid_in_if.sink            in_i,
  input  logic               can_push_i,
  output logic               push_o,
  output mpid_pkg::q_item_t  item_o
);
  import mpid_pkg::*;

  localparam logic [6:0]  NCH = 7'(NUM_CHANNELS);
  localparam logic [15:0] MID = 16'(ADC_MIDSCALE);

  logic signed [18:0] err_wide;
  logic               in_range;

  assign in_i.ready = can_push_i;
  assign in_range   = {3'b000, in_i.channel} < NCH;
  assign push_o     = in_i.valid && can_push_i && in_range;

  always_comb begin
    err_wide = {{7{in_i.target_current[SAMPLE_W-1]}}, in_i.target_current}
             - {7'b0, in_i.adc_sample} + {3'b000, MID};
    item_o.channel = in_i.channel;
    if (err_wide > 19'sd4095) begin
      item_o.err = ERR_MAX;
    end else if (err_wide < -19'sd4096) begin
      item_o.err = ERR_MIN;
    end else begin
      item_o.err = err_wide[ERR_W-1:0];
    end
  end

endmodule

>>> design/mpid_queue.sv
// Short queue of classified requests between the front and back ends.
// Depends on mpid_pkg.
module mpid_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mpid_pkg::q_item_t push_item_i,
  output logic              can_push_o,
  input  logic              pop_i,
  output mpid_pkg::q_item_t pop_item_o,
  output logic              nonempty_o
);
  import mpid_pkg::*;

  localparam int DEPTH = 1 << QUEUE_AW;

  q_item_t             store_q [DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_AW:0]   count_q;

  assign can_push_o = count_q != (QUEUE_AW+1)'(DEPTH);
  assign nonempty_o = count_q != '0;
  assign pop_item_o = store_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

>>> design/mpid_back.sv
// Back end: per-channel state memory, gain products, accumulate and clamp,
// and the result register. Depends on mpid_pkg and mpid_out_if.
module mpid_back #(
  parameter int unsigned NUM_CHANNELS   = mpid_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned INITIAL_OUTPUT = mpid_pkg::INITIAL_OUTPUT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mpid_pkg::cfg_t    cfg_i,
  input  logic              nonempty_i,
  input  mpid_pkg::q_item_t item_i,
  output logic              pop_o,
  mpid_out_if.source        out_o
);
  import mpid_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam chan_state_t RESET_STATE = '{acc: {16'(INITIAL_OUTPUT), 16'h0000},
                                          err_prev: '0, err_prev2: '0};

  chan_state_t              state_mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]  written_q;
  chan_state_t              rd_data_q;
  logic                     rd_written_q;

  logic                     byp_vld_q;
  logic [CH_FIELD_W-1:0]    byp_ch_q;
  chan_state_t              byp_state_q;

  logic                     s1_vld_q;
  q_item_t                  s1_item_q;
  logic                     s2_vld_q;
  logic [CH_FIELD_W-1:0]    s2_ch_q;
  logic signed [ERR_W-1:0]  s2_err_q, s2_err_prev_q;
  logic [ACC_W-1:0]         s2_acc_q;
  logic signed [31:0]       prod_p_q, prod_i_q, prod_d_q;

  logic                     out_vld_q;
  logic [CH_FIELD_W-1:0]    out_ch_q;
  logic [VAL_W-1:0]         out_cmp_q;

  logic                     s1_adv, s2_fire;
  logic [CH_W-1:0]          rd_idx, wr_idx;
  chan_state_t              old_state, new_state;
  logic signed [13:0]       diff1;
  logic signed [14:0]       diff2;
  logic signed [16:0]       kp_s, ki_s, kd_s;
  logic signed [31:0]       prod_p_d, prod_i_d, prod_d_d;
  logic signed [34:0]       sum, hi_lim, lim, ceil_s, floor_s;

  assign pop_o   = nonempty_i && !s1_vld_q;
  assign s1_adv  = s1_vld_q && !s2_vld_q;
  assign s2_fire = s2_vld_q && (!out_vld_q || out_o.ready);
  assign rd_idx  = CH_W'(item_i.channel);
  assign wr_idx  = CH_W'(s2_ch_q);

  always_comb begin
    if (byp_vld_q && byp_ch_q == s1_item_q.channel) begin
      old_state = byp_state_q;
    end else if (rd_written_q) begin
      old_state = rd_data_q;
    end else begin
      old_state = RESET_STATE;
    end
    diff1    = 14'(s1_item_q.err) - 14'(old_state.err_prev);
    diff2    = 15'(s1_item_q.err) - (15'(old_state.err_prev) <<< 1)
             + 15'(old_state.err_prev2);
    kp_s     = $signed({1'b0, cfg_i.gain_p});
    ki_s     = $signed({1'b0, cfg_i.gain_i});
    kd_s     = $signed({1'b0, cfg_i.gain_d});
    prod_p_d = kp_s * diff1;
    prod_i_d = ki_s * s1_item_q.err;
    prod_d_d = kd_s * diff2;
  end

  always_comb begin
    sum     = $signed({3'b000, s2_acc_q}) + 35'(prod_p_q) + 35'(prod_i_q)
            + 35'(prod_d_q);
    ceil_s  = $signed({3'b000, cfg_i.out_ceil, 16'h0000});
    floor_s = $signed({3'b000, cfg_i.out_floor, 16'h0000});
    hi_lim  = (sum > ceil_s) ? ceil_s : sum;
    lim     = (hi_lim < floor_s) ? floor_s : hi_lim;
    new_state.acc       = lim[ACC_W-1:0];
    new_state.err_prev  = s2_err_q;
    new_state.err_prev2 = s2_err_prev_q;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rd_data_q <= state_mem[rd_idx];
    end
    if (s2_fire) begin
      state_mem[wr_idx] <= new_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
      byp_vld_q    <= 1'b0;
      s1_vld_q     <= 1'b0;
      s2_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      if (pop_o) begin
        rd_written_q <= written_q[rd_idx];
        s1_vld_q     <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_vld_q <= 1'b1;
      end else if (s2_fire) begin
        s2_vld_q <= 1'b0;
      end
      if (s2_fire) begin
        written_q[wr_idx] <= 1'b1;
        byp_vld_q         <= 1'b1;
        out_vld_q         <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_item_q <= item_i;
    end
    if (s1_adv) begin
      s2_ch_q       <= s1_item_q.channel;
      s2_err_q      <= s1_item_q.err;
      s2_err_prev_q <= old_state.err_prev;
      s2_acc_q      <= old_state.acc;
      prod_p_q      <= prod_p_d;
      prod_i_q      <= prod_i_d;
      prod_d_q      <= prod_d_d;
    end
    if (s2_fire) begin
      byp_ch_q    <= s2_ch_q;
      byp_state_q <= new_state;
      out_ch_q    <= s2_ch_q;
      out_cmp_q   <= new_state.acc[ACC_W-1:ACC_W-VAL_W];
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.channel_out   = out_ch_q;
  assign out_o.compare_value = out_cmp_q;

endmodule

>>> verif/tb_multichannel_incremental_pid.sv
// Testbench for the twelve-channel incremental PID controller.
// Drives requests and register writes, predicts every compare value and checks each result.
// Depends on mpid_pkg, mpid_ifs and the multichannel_incremental_pid top level.
`timescale 1ns / 1ps

module tb_multichannel_incremental_pid;
  import mpid_pkg::*;

  localparam int unsigned NUM_CH      = NUM_CHANNELS_DEF;
  localparam longint      MIDSCALE    = ADC_MIDSCALE_DEF;
  localparam int unsigned INIT_OUT    = INITIAL_OUTPUT_DEF;
  localparam int          SETTLE      = 16;
  localparam int          HOLD_CYCLES = 300;
  localparam int          LIMIT       = 400000;
  localparam int          MAX_LINES   = 60;

  typedef struct {
    logic [CH_FIELD_W-1:0] channel;
    logic [VAL_W-1:0]      compare_value;
  } drive_result_t;

  class pid_loop_scoreboard;
    cfg_t                    regs;
    logic [ACC_W-1:0]        acc [NUM_CH];
    logic signed [ERR_W-1:0] err1 [NUM_CH];
    logic signed [ERR_W-1:0] err2 [NUM_CH];
    drive_result_t           pending_compares [$];

    function new();
      regs.gain_p    = 16'd480;
      regs.gain_i    = 16'd480;
      regs.gain_d    = 16'd0;
      regs.out_floor = 16'd0;
      regs.out_ceil  = 16'd2000;
      for (int c = 0; c < NUM_CH; c++) begin
        acc[c]  = ACC_W'(INIT_OUT) << 16;
        err1[c] = '0;
        err2[c] = '0;
      end
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
      case (idx)
        CFG_GAIN_P:    regs.gain_p = data;
        CFG_GAIN_I:    regs.gain_i = data;
        CFG_GAIN_D:    regs.gain_d = data;
        CFG_OUT_FLOOR: regs.out_floor = data;
        CFG_OUT_CEIL:  regs.out_ceil = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_compares.size();
    endfunction

    function void note_request(logic [CH_FIELD_W-1:0] ch, logic signed [SAMPLE_W-1:0] tgt,
                               logic [SAMPLE_W-1:0] adc);
      longint        e, e1, e2, inc, nxt, hi, lo;
      drive_result_t r;
      if (ch >= NUM_CH) return;
      e = longint'(tgt) - (longint'(adc) - MIDSCALE);
      if (e > longint'(ERR_MAX)) e = longint'(ERR_MAX);
      if (e < longint'(ERR_MIN)) e = longint'(ERR_MIN);
      e1 = longint'(err1[ch]);
      e2 = longint'(err2[ch]);
      inc = longint'(regs.gain_p) * (e - e1) + longint'(regs.gain_i) * e
          + longint'(regs.gain_d) * (e - 2 * e1 + e2);
      nxt = longint'(acc[ch]) + inc;
      hi = longint'(regs.out_ceil) << 16;
      lo = longint'(regs.out_floor) << 16;
      if (nxt > hi) nxt = hi;
      if (nxt < lo) nxt = lo;
      acc[ch]  = nxt[ACC_W-1:0];
      err2[ch] = err1[ch];
      err1[ch] = e[ERR_W-1:0];
      r.channel       = ch;
      r.compare_value = acc[ch][ACC_W-1:16];
      pending_compares.push_back(r);
    endfunction

    function bit check_result(logic [CH_FIELD_W-1:0] ch, logic [VAL_W-1:0] val,
                              output string why);
      drive_result_t want;
      why = "";
      if (pending_compares.size() == 0) begin
        why = $sformatf("unexpected result channel %0d value %0d", ch, val);
        return 1'b1;
      end
      want = pending_compares.pop_front();
      if (ch !== want.channel)
        why = {why, $sformatf(" channel_out got %0d want %0d;", ch, want.channel)};
      if (val !== want.compare_value)
        why = {why, $sformatf(" compare_value got %0d want %0d (channel %0d);",
                              val, want.compare_value, want.channel)};
      return why != "";
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic hold_off;
  bit   hold_req;
  int   fails;
  int   cycle_count;

  pid_loop_scoreboard sb = new();

  mpid_in_if  in_if ();
  mpid_cfg_if cfg_if ();
  mpid_out_if out_if ();

  multichannel_incremental_pid dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  task automatic report(input string why);
    fails++;
    if (fails <= MAX_LINES) $display("[cycle %0d] mismatch:%s", cycle_count, why);
  endtask

  task automatic send_request(input logic [CH_FIELD_W-1:0] ch,
                              input logic signed [SAMPLE_W-1:0] tgt,
                              input logic [SAMPLE_W-1:0] adc);
    in_if.valid          <= 1'b1;
    in_if.channel        <= ch;
    in_if.target_current <= tgt;
    in_if.adc_sample     <= adc;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_request(ch, tgt, adc);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.set_reg(idx, data);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic apply_settings(input int kp, input int ki, input int kd, input int floor_v,
                                input int ceil_v, input bit with_unused);
    int k;
    wait_drained();
    write_reg(CFG_GAIN_P, kp[VAL_W-1:0]);
    write_reg(CFG_GAIN_I, ki[VAL_W-1:0]);
    write_reg(CFG_GAIN_D, kd[VAL_W-1:0]);
    write_reg(CFG_OUT_FLOOR, floor_v[VAL_W-1:0]);
    write_reg(CFG_OUT_CEIL, ceil_v[VAL_W-1:0]);
    if (with_unused) begin
      for (k = int'(CFG_OUT_CEIL) + 1; k < (1 << CFG_IDX_W); k++) begin
        write_reg(k[CFG_IDX_W-1:0], VAL_W'($urandom));
      end
    end
    cfg_if.valid <= 1'b0;
  endtask

  // Most requests track the setpoint closely, as a running loop would; the rest are
  // unrelated samples or requests for channels that do not exist.
  function automatic bit pick_request(output logic [CH_FIELD_W-1:0] ch,
                                      output logic signed [SAMPLE_W-1:0] tgt,
                                      output logic [SAMPLE_W-1:0] adc);
    int r;
    int a;
    r   = $urandom_range(0, 99);
    tgt = SAMPLE_W'($urandom);
    adc = SAMPLE_W'($urandom);
    if (r < 10) begin
      ch = CH_FIELD_W'($urandom_range(NUM_CH, (1 << CH_FIELD_W) - 1));
      return 1'b0;
    end
    ch = CH_FIELD_W'($urandom_range(0, NUM_CH - 1));
    if (r >= 35) begin
      a = int'(tgt) + int'(MIDSCALE) + $urandom_range(0, 128) - 64;
      if (a < 0) a = 0;
      if (a > (1 << SAMPLE_W) - 1) a = (1 << SAMPLE_W) - 1;
      adc = a[SAMPLE_W-1:0];
    end
    return 1'b1;
  endfunction

  task automatic run_requests(input int count, input int squeeze_at);
    int                         sent;
    int                         burst_left;
    int                         gap;
    bit                         counts;
    logic [CH_FIELD_W-1:0]      ch;
    logic signed [SAMPLE_W-1:0] tgt;
    logic [SAMPLE_W-1:0]        adc;
    sent = 0;
    burst_left = $urandom_range(1, 12);
    while (sent < count) begin
      counts = pick_request(ch, tgt, adc);
      send_request(ch, tgt, adc);
      if (counts) begin
        sent++;
        if (sent == squeeze_at) hold_req = 1'b1;
      end
      burst_left--;
      if (sent < count && burst_left == 0) begin
        if ($urandom_range(0, 5) == 0) begin
          burst_left = $urandom_range(20, 40);
          gap = 0;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
        if (gap > 0) begin
          in_if.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
    in_if.valid <= 1'b0;
  endtask

  initial begin : result_sink
    int    period;
    int    duty;
    int    ph;
    int    left;
    string why;
    out_if.ready <= 1'b0;
    period = 1;
    duty = 1;
    ph = 0;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        if (sb.check_result(out_if.channel_out, out_if.compare_value, why)) report(why);
      end
      if (left == 0) begin
        left = $urandom_range(20, 120);
        if ($urandom_range(0, 3) == 0) begin
          period = 1;
          duty = 1;
        end else begin
          period = $urandom_range(2, 9);
          duty = $urandom_range(1, period - 1);
        end
        ph = 0;
      end
      left--;
      out_if.ready <= !hold_off && (ph < duty);
      ph = (ph + 1) % period;
    end
  end

  initial begin : back_pressure
    hold_off <= 1'b0;
    wait (hold_req);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    wait (cycle_count >= LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    rst_ni               <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.channel        <= '0;
    in_if.target_current <= '0;
    in_if.adc_sample     <= '0;
    cfg_if.valid         <= 1'b0;
    cfg_if.index         <= CFG_GAIN_P;
    cfg_if.data          <= '0;
    fails = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: zero error, largest errors of both signs, each repeated on
    // one channel, both edge channels, and channel numbers that must be dropped.
    send_request(0, 0, 2048);
    send_request(0, 2047, 0);
    send_request(0, 2047, 0);
    send_request(0, 2047, 0);
    send_request(1, -2048, 4095);
    send_request(1, -2048, 4095);
    send_request(1, -2048, 4095);
    send_request(11, 2047, 4095);
    send_request(11, -2048, 0);
    send_request(12, 100, 100);
    send_request(15, -1, 4095);
    send_request(5, 10, 2000);
    send_request(5, 10, 2100);
    send_request(10, -700, 1234);
    send_request(CH_FIELD_W'(NUM_CH - 1), 0, 2048);
    in_if.valid <= 1'b0;

    apply_settings(65535, 65535, 65535, 0, 65535, 1'b0);
    run_requests(60, 0);
    // Floor above ceiling: the floor takes precedence.
    apply_settings(700, 300, 150, 1500, 500, 1'b0);
    run_requests(30, 0);
    apply_settings($urandom_range(0, 2000), $urandom_range(0, 1000), $urandom_range(0, 3000),
                   $urandom_range(0, 800), $urandom_range(1000, 4000), 1'b0);
    run_requests(180, 30);
    apply_settings($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 65535), 1'b1);
    run_requests(100, 0);
    apply_settings(0, 0, 0, 0, 0, 1'b0);
    run_requests(20, 0);
    apply_settings(480, 480, 200, 0, 2000, 1'b0);
    run_requests(160, 0);

    wait_drained();
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
